### rtl/nbbsr_pkg.sv
// ============================================================================
// nbbsr_pkg
// Shared constants and types for the NAND bad block skip and remap unit.
// ============================================================================
`default_nettype none

package nbbsr_pkg;

   // configuration defaults and fixed geometry
   localparam int MAX_BLOCKS_DEFAULT     = 8192;
   localparam int BLOCKS_PER_MIB_DEFAULT = 64;
   localparam int PAGES_PER_BLOCK        = 32;
   localparam int PAGE_OFFSET_W          = $clog2(PAGES_PER_BLOCK);

   // field widths
   localparam int MODE_W      = 2;
   localparam int MARK_W      = 8;
   localparam int PART_W      = 2;
   localparam int SECTOR_W    = 18;
   localparam int PAGE_W      = 18;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 14;
   localparam int MIB_W       = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [MARK_W-1:0] GOOD_MARK = 8'hFF;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MIB  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMDISK_MIB = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GENERAL_MIB = 2'd2;

   localparam logic [MIB_W-1:0] KERNEL_MIB_RESET  = 8'd1;
   localparam logic [MIB_W-1:0] RAMDISK_MIB_RESET = 8'd3;
   localparam logic [MIB_W-1:0] GENERAL_MIB_RESET = 8'd124;

   // partition numbers
   localparam logic [PART_W-1:0] PART_KERNEL  = 2'd0;
   localparam logic [PART_W-1:0] PART_RAMDISK = 2'd1;
   localparam logic [PART_W-1:0] PART_GENERAL = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_RESTART   = 2'd0,
      MODE_MARK      = 2'd1,
      MODE_TRANSLATE = 2'd2,
      MODE_UNUSED    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_PART = 2'd1,
      STATUS_UNMAPPED = 2'd2,
      STATUS_OUTSIDE  = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;   // request taken this cycle
      logic finish;   // map data valid, load result registers
   } ctl_cmd_type;

endpackage

`default_nettype wire

### rtl/nbbsr_ram.sv
// ============================================================================
// nbbsr_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module nbbsr_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/nbbsr_ctrl.sv
// ============================================================================
// nbbsr_ctrl
// Request sequencer: accept, wait in the lookup state for the map read, issue result.
// ============================================================================
`default_nettype none

module nbbsr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output nbbsr_pkg::ctl_cmd_type       cmd,
   output logic                         rsp_strobe
);

   import nbbsr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      strobe_in = cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

### rtl/nbbsr_dpath.sv
// ============================================================================
// nbbsr_dpath
// Scan counters, partition registers, good block map and address translation.
// ============================================================================
`default_nettype none

module nbbsr_dpath #(
   parameter int MAX_BLOCKS     = nbbsr_pkg::MAX_BLOCKS_DEFAULT,
   parameter int BLOCKS_PER_MIB = nbbsr_pkg::BLOCKS_PER_MIB_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  nbbsr_pkg::ctl_cmd_type                     cmd,
   input  wire logic [nbbsr_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [nbbsr_pkg::MARK_W-1:0]          req_mark_byte,
   input  wire logic [nbbsr_pkg::PART_W-1:0]          req_partition,
   input  wire logic [nbbsr_pkg::SECTOR_W-1:0]        req_sector,
   input  wire logic                                  csr_write_enable,
   input  wire logic [nbbsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [nbbsr_pkg::MIB_W-1:0]           csr_write_data,
   output logic      [nbbsr_pkg::PAGE_W-1:0]          rsp_page,
   output logic      [nbbsr_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [nbbsr_pkg::COUNT_W-1:0]         rsp_bad_count
);

   import nbbsr_pkg::*;

   localparam int AW    = $clog2(MAX_BLOCKS);
   localparam int CW    = $clog2(MAX_BLOCKS + 1);
   localparam int BW    = MIB_W + 2 + $clog2(BLOCKS_PER_MIB);
   localparam int SBW   = SECTOR_W - PAGE_OFFSET_W;
   localparam int RW    = ((BW > SBW) ? BW : SBW) + 1;
   localparam int CMPW  = (RW > CW) ? RW : CW;
   localparam int MCMPW = (AW > BW) ? AW : BW;

   // configuration
   logic [MIB_W-1:0] kernel_mib_ff, ramdisk_mib_ff, general_mib_ff;

   // scan state
   logic [CW-1:0] scan_index_ff, scan_index_in;
   logic [CW-1:0] good_count_ff, good_count_in;
   logic [CW-1:0] bad_total_ff,  bad_total_in;

   // lookup stage
   logic [STATUS_W-1:0]      status_pre_ff, status_pre_in;
   logic                     lookup_ff, lookup_in;
   logic [BW-1:0]            base_ff, base_in;
   logic [BW-1:0]            limit_ff, limit_in;
   logic [PAGE_OFFSET_W-1:0] offset_ff;

   // result registers
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  bad_count_ff;

   // map port
   logic          map_we;
   logic [AW-1:0] map_rd_data;
   logic [RW-1:0] real_block;

   logic [BW-1:0] kernel_blocks, ramdisk_blocks, general_blocks, general_base;
   logic          bad_part, unmapped, outside, scan_open, is_mark, is_good;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mib_ff  <= KERNEL_MIB_RESET;
         ramdisk_mib_ff <= RAMDISK_MIB_RESET;
         general_mib_ff <= GENERAL_MIB_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_KERNEL_MIB) begin
            kernel_mib_ff <= csr_write_data;
         end
         if (csr_index == CSR_RAMDISK_MIB) begin
            ramdisk_mib_ff <= csr_write_data;
         end
         if (csr_index == CSR_GENERAL_MIB) begin
            general_mib_ff <= csr_write_data;
         end
      end
   end

   // partition geometry in blocks
   assign kernel_blocks  = BW'(kernel_mib_ff)  * BW'(BLOCKS_PER_MIB);
   assign ramdisk_blocks = BW'(ramdisk_mib_ff) * BW'(BLOCKS_PER_MIB);
   assign general_blocks = BW'(general_mib_ff) * BW'(BLOCKS_PER_MIB);
   assign general_base   = (BW'(kernel_mib_ff) + BW'(ramdisk_mib_ff)) * BW'(BLOCKS_PER_MIB);

   always_comb begin
      bad_part = 1'b0;
      base_in  = '0;
      limit_in = kernel_blocks;
      if (req_partition == PART_RAMDISK) begin
         base_in  = kernel_blocks;
         limit_in = kernel_blocks + ramdisk_blocks;
      end else if (req_partition == PART_GENERAL) begin
         base_in  = general_base;
         limit_in = general_base + general_blocks;
      end else if (req_partition != PART_KERNEL) begin
         bad_part = 1'b1;
      end
   end

   assign real_block = RW'(base_in) + RW'(req_sector[SECTOR_W-1:PAGE_OFFSET_W]);
   // entries at or past good_count were not written since restart
   assign unmapped   = (CMPW'(real_block) >= CMPW'(good_count_ff));

   assign is_mark   = (req_mode == MODE_MARK);
   assign is_good   = (req_mark_byte == GOOD_MARK);
   assign scan_open = (scan_index_ff < CW'(MAX_BLOCKS));
   assign map_we    = cmd.accept && is_mark && scan_open && is_good
                      && (good_count_ff < CW'(MAX_BLOCKS));

   always_comb begin
      scan_index_in = scan_index_ff;
      good_count_in = good_count_ff;
      bad_total_in  = bad_total_ff;
      status_pre_in = STATUS_OK;
      lookup_in     = 1'b0;
      if (req_mode == MODE_RESTART) begin
         scan_index_in = '0;
         good_count_in = '0;
         bad_total_in  = '0;
      end else if (is_mark) begin
         if (scan_open) begin
            scan_index_in = scan_index_ff + CW'(1);
            if (!is_good) begin
               bad_total_in = bad_total_ff + CW'(1);
            end
         end
         if (map_we) begin
            good_count_in = good_count_ff + CW'(1);
         end
      end else if (req_mode == MODE_TRANSLATE) begin
         if (bad_part) begin
            status_pre_in = STATUS_BAD_PART;
         end else if (unmapped) begin
            status_pre_in = STATUS_UNMAPPED;
         end else begin
            lookup_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_index_ff <= '0;
         good_count_ff <= '0;
         bad_total_ff  <= '0;
         lookup_ff     <= 1'b0;
      end else if (cmd.accept) begin
         scan_index_ff <= scan_index_in;
         good_count_ff <= good_count_in;
         bad_total_ff  <= bad_total_in;
         lookup_ff     <= lookup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_pre_ff <= status_pre_in;
         base_ff       <= base_in;
         limit_ff      <= limit_in;
         offset_ff     <= req_sector[PAGE_OFFSET_W-1:0];
      end
   end

   nbbsr_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (good_count_ff[AW-1:0]),
      .wr_data (scan_index_ff[AW-1:0]),
      .rd_addr (real_block[AW-1:0]),
      .rd_data (map_rd_data)
   );

   assign outside = (MCMPW'(map_rd_data) < MCMPW'(base_ff))
                    || (MCMPW'(map_rd_data) >= MCMPW'(limit_ff));

   always_comb begin
      page_in   = '0;
      status_in = status_pre_ff;
      if (lookup_ff) begin
         if (outside) begin
            status_in = STATUS_OUTSIDE;
         end else begin
            status_in = STATUS_OK;
            page_in   = PAGE_W'({map_rd_data, offset_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         page_ff      <= page_in;
         status_ff    <= status_in;
         bad_count_ff <= COUNT_W'(bad_total_ff);
      end
   end

   assign rsp_page      = page_ff;
   assign rsp_status    = status_ff;
   assign rsp_bad_count = bad_count_ff;

endmodule

`default_nettype wire

### rtl/nand_bad_block_skip_remap_unit.sv
// ============================================================================
// nand_bad_block_skip_remap_unit
// Builds a good block map from scanned bad markers and translates partition
// sectors to physical pages through that map.
// ============================================================================
// Usage:
//   A request is taken on a rising edge with start high and busy low. The
//   req_mode port selects restart scan, block marker byte or sector translate;
//   the other req_ ports carry the marker, partition and sector.
//   Each request gives one result: rsp_page, rsp_status and rsp_bad_count are
//   valid for the single cycle in which rsp_strobe is high, which follows the
//   lookup state. The receiver has no way to stall the result.
//   busy is high in the lookup state after a request while the good block map
//   is read through its registered read port. A new request may be taken in
//   the cycle the result is shown. The csr_ port writes the three partition
//   sizes in MiB, only while idle, a rule for the user that the block does not
//   enforce. Reset clears the scan counters and loads the default partition
//   sizes. The map memory is not cleared; entries past the good count read as
//   unmapped, so no clearing pass is needed and requests are taken right away.
// ============================================================================
`default_nettype none

module nand_bad_block_skip_remap_unit #(
   parameter int MAX_BLOCKS     = nbbsr_pkg::MAX_BLOCKS_DEFAULT,
   parameter int BLOCKS_PER_MIB = nbbsr_pkg::BLOCKS_PER_MIB_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [nbbsr_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [nbbsr_pkg::MARK_W-1:0]          req_mark_byte,
   input  wire logic [nbbsr_pkg::PART_W-1:0]          req_partition,
   input  wire logic [nbbsr_pkg::SECTOR_W-1:0]        req_sector,
   output logic                                       rsp_strobe,
   output logic      [nbbsr_pkg::PAGE_W-1:0]          rsp_page,
   output logic      [nbbsr_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [nbbsr_pkg::COUNT_W-1:0]         rsp_bad_count,
   input  wire logic                                  csr_write_enable,
   input  wire logic [nbbsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [nbbsr_pkg::MIB_W-1:0]           csr_write_data
);

   import nbbsr_pkg::*;

   ctl_cmd_type cmd;

   nbbsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   nbbsr_dpath #(
      .MAX_BLOCKS     (MAX_BLOCKS),
      .BLOCKS_PER_MIB (BLOCKS_PER_MIB)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_mark_byte    (req_mark_byte),
      .req_partition    (req_partition),
      .req_sector       (req_sector),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_page         (rsp_page),
      .rsp_status       (rsp_status),
      .rsp_bad_count    (rsp_bad_count)
   );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the NAND bad block skip and remap unit. Requests
// build good block maps through scans of varying length and then translate
// partition sectors against them under several partition layouts.
// A scoreboard predicts every result and compares it field by field.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nbbsr_pkg::*;

   localparam int                MAP_DEPTH    = MAX_BLOCKS_DEFAULT;
   localparam int                BLK_PER_MIB  = BLOCKS_PER_MIB_DEFAULT;
   localparam logic [PART_W-1:0] PART_INVALID = 2'd3;
   localparam logic [MARK_W-1:0] BAD_MARK_MAX = 8'hFE;

   typedef struct {
      logic [PAGE_W-1:0]  page;
      status_type         status;
      logic [COUNT_W-1:0] bad_count;
   } remap_result_type;

   // ------------------------------------------------------------------------
   // Scoreboard: own copy of the skip map, scan counters and partition sizes
   // ------------------------------------------------------------------------
   class skip_map_scoreboard;
      logic [12:0]      block_map [MAP_DEPTH];
      int               scan_idx;
      int               good_cnt;
      int               bad_tot;
      int               kernel_mib  = KERNEL_MIB_RESET;
      int               ramdisk_mib = RAMDISK_MIB_RESET;
      int               general_mib = GENERAL_MIB_RESET;
      remap_result_type pending_results[$];
      int               mismatches;
      int               checked;
      int               accepted;
      int               peak_bad;
      int               mode_seen [4];
      int               status_seen [4];

      function void set_size(logic [CSR_INDEX_W-1:0] index, logic [MIB_W-1:0] value);
         case (index)
            CSR_KERNEL_MIB:  kernel_mib  = value;
            CSR_RAMDISK_MIB: ramdisk_mib = value;
            CSR_GENERAL_MIB: general_mib = value;
            default: ;
         endcase
      endfunction

      function int part_base(logic [PART_W-1:0] part);
         case (part)
            PART_RAMDISK: return kernel_mib * BLK_PER_MIB;
            PART_GENERAL: return (kernel_mib + ramdisk_mib) * BLK_PER_MIB;
            default:      return 0;
         endcase
      endfunction

      function int part_span(logic [PART_W-1:0] part);
         case (part)
            PART_KERNEL:  return kernel_mib * BLK_PER_MIB;
            PART_RAMDISK: return ramdisk_mib * BLK_PER_MIB;
            PART_GENERAL: return general_mib * BLK_PER_MIB;
            default:      return 0;
         endcase
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // apply one accepted request and queue the result it must produce
      function void note_request(mode_type mode, logic [MARK_W-1:0] mark,
                                 logic [PART_W-1:0] part, logic [SECTOR_W-1:0] sector);
         remap_result_type want;
         int               base;
         int               span;
         int               blk_index;
         int               mapped;
         want.page   = '0;
         want.status = STATUS_OK;
         accepted++;
         mode_seen[mode]++;
         case (mode)
            MODE_RESTART: begin
               scan_idx = 0;
               good_cnt = 0;
               bad_tot  = 0;
            end
            MODE_MARK: begin
               // marks past a full scan are dropped
               if (scan_idx < MAP_DEPTH) begin
                  if (mark != GOOD_MARK) begin
                     bad_tot++;
                  end else begin
                     block_map[good_cnt] = 13'(scan_idx);
                     good_cnt++;
                  end
                  scan_idx++;
               end
            end
            MODE_TRANSLATE: begin
               if (part == PART_INVALID) begin
                  want.status = STATUS_BAD_PART;
               end else begin
                  base      = part_base(part);
                  span      = part_span(part);
                  blk_index = base + int'(sector) / PAGES_PER_BLOCK;
                  if (blk_index >= good_cnt || blk_index >= MAP_DEPTH) begin
                     want.status = STATUS_UNMAPPED;
                  end else begin
                     mapped = block_map[blk_index];
                     if (mapped < base || mapped >= base + span) begin
                        want.status = STATUS_OUTSIDE;
                     end else begin
                        want.page = PAGE_W'(mapped * PAGES_PER_BLOCK
                                            + int'(sector) % PAGES_PER_BLOCK);
                     end
                  end
               end
            end
            default: ;
         endcase
         if (bad_tot > peak_bad) peak_bad = bad_tot;
         want.bad_count = COUNT_W'(bad_tot);
         pending_results.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic [PAGE_W-1:0] page, logic [STATUS_W-1:0] status,
                        logic [COUNT_W-1:0] bad_count);
         remap_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with none pending: page %0d status %0d bad %0d",
                                      page, status, bad_count));
            return;
         end
         want = pending_results.pop_front();
         checked++;
         status_seen[want.status]++;
         if (page !== want.page)
            report_mismatch($sformatf("result %0d page %0h, want %0h", checked, page,
                                      want.page));
         if (status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %s", checked, status,
                                      want.status.name()));
         if (bad_count !== want.bad_count)
            report_mismatch($sformatf("result %0d bad_count %0d, want %0d", checked,
                                      bad_count, want.bad_count));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // DUT and stimulus signals
   // ------------------------------------------------------------------------
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic                   busy;
   logic [MODE_W-1:0]      req_mode         = '0;
   logic [MARK_W-1:0]      req_mark_byte    = '0;
   logic [PART_W-1:0]      req_partition    = '0;
   logic [SECTOR_W-1:0]    req_sector       = '0;
   logic                   rsp_strobe;
   logic [PAGE_W-1:0]      rsp_page;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_W-1:0]     rsp_bad_count;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [MIB_W-1:0]       csr_write_data   = '0;
   bit                     gaps_on          = 1'b1;

   skip_map_scoreboard skip_map = new();

   nand_bad_block_skip_remap_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_mark_byte    (req_mark_byte),
      .req_partition    (req_partition),
      .req_sector       (req_sector),
      .rsp_strobe       (rsp_strobe),
      .rsp_page         (rsp_page),
      .rsp_status       (rsp_status),
      .rsp_bad_count    (rsp_bad_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         skip_map.check_result(rsp_page, rsp_status, rsp_bad_count);
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   // start stays high after acceptance until a gap or a drain drops it, or the
   // next request drives it again with new fields
   task automatic send_request(input mode_type mode, input logic [MARK_W-1:0] mark,
                               input logic [PART_W-1:0] part,
                               input logic [SECTOR_W-1:0] sector);
      @(negedge clock);
      start         = 1'b1;
      req_mode      = mode;
      req_mark_byte = mark;
      req_partition = part;
      req_sector    = sector;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      skip_map.note_request(mode, mark, part, sector);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!gaps_on || pick < 55) return;
      if (pick < 90) idle_for($urandom_range(1, 3));
      else           idle_for($urandom_range(4, 40));
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (skip_map.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_sizes(input logic [MIB_W-1:0] kernel, input logic [MIB_W-1:0] ramdisk,
                              input logic [MIB_W-1:0] general);
      logic [MIB_W-1:0]       vals [3];
      logic [CSR_INDEX_W-1:0] idx [3];
      vals = '{kernel, ramdisk, general};
      idx  = '{CSR_KERNEL_MIB, CSR_RAMDISK_MIB, CSR_GENERAL_MIB};
      drain_results();
      for (int i = 0; i < 3; i++) begin
         @(negedge clock);
         csr_write_enable = 1'b1;
         csr_index        = idx[i];
         csr_write_data   = vals[i];
         @(posedge clock);
         skip_map.set_size(idx[i], vals[i]);
      end
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [MIB_W-1:0] pick_size();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return MIB_W'(128);
         2, 3:    return MIB_W'($urandom_range(0, 4));
         default: return MIB_W'($urandom_range(0, 128));
      endcase
   endfunction

   // unrelated request fields carry random junk
   task automatic scan_blocks(input int count, input int bad_pct);
      logic [MARK_W-1:0] mark;
      for (int i = 0; i < count; i++) begin
         mark = ($urandom_range(0, 99) < bad_pct) ? MARK_W'($urandom_range(0, BAD_MARK_MAX))
                                                  : GOOD_MARK;
         send_request(MODE_MARK, mark, PART_W'($urandom), SECTOR_W'($urandom));
         random_gap();
      end
   endtask

   task automatic translate_some(input int count);
      logic [PART_W-1:0]   part;
      logic [SECTOR_W-1:0] sector;
      int                  base;
      int                  span;
      int                  blk;
      int                  pick;
      for (int i = 0; i < count; i++) begin
         part = ($urandom_range(0, 99) < 88) ? PART_W'($urandom_range(0, 2)) : PART_INVALID;
         base = skip_map.part_base(part);
         span = skip_map.part_span(part);
         pick = $urandom_range(0, 99);
         if (pick < 20 && span > 0) begin
            // near the partition end, where skipped blocks push past the bound
            blk = span - $urandom_range(1, 3);
         end else if (pick < 75) begin
            blk = $urandom_range(0, (skip_map.good_cnt > base) ?
                                    skip_map.good_cnt - base + 1 : 2);
         end else begin
            blk = -1;
         end
         if (blk < 0 || blk >= MAP_DEPTH) sector = SECTOR_W'($urandom);
         else sector = SECTOR_W'(blk * PAGES_PER_BLOCK + $urandom_range(0, PAGES_PER_BLOCK - 1));
         send_request(MODE_TRANSLATE, MARK_W'($urandom), part, sector);
         random_gap();
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int first;
      int n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: before any scan, bad partition, unused mode, small scan
      send_request(MODE_TRANSLATE, GOOD_MARK, PART_KERNEL, '0);
      send_request(MODE_TRANSLATE, '0, PART_INVALID, '1);
      send_request(MODE_UNUSED, GOOD_MARK, PART_GENERAL, '1);
      send_request(MODE_RESTART, '0, '0, '0);
      send_request(MODE_MARK, 8'h00, '0, '0);
      send_request(MODE_MARK, GOOD_MARK, '0, '0);
      send_request(MODE_MARK, BAD_MARK_MAX, '0, '0);
      random_gap();
      repeat (3) send_request(MODE_MARK, GOOD_MARK, '1, '1);
      send_request(MODE_MARK, 8'h7F, '0, '0);
      send_request(MODE_MARK, 8'h80, '0, '0);
      send_request(MODE_UNUSED, GOOD_MARK, '0, '0);
      send_request(MODE_TRANSLATE, '0, PART_KERNEL, 18'd0);
      send_request(MODE_TRANSLATE, '0, PART_KERNEL, 18'd127);
      send_request(MODE_TRANSLATE, '0, PART_KERNEL, 18'd128);
      send_request(MODE_TRANSLATE, '0, PART_RAMDISK, 18'd0);
      send_request(MODE_TRANSLATE, '0, PART_GENERAL, '1);
      send_request(MODE_TRANSLATE, '0, PART_INVALID, '0);
      write_sizes('0, '0, '0);
      send_request(MODE_TRANSLATE, '0, PART_KERNEL, 18'd0);
      send_request(MODE_TRANSLATE, '0, PART_GENERAL, 18'd5);
      send_request(MODE_RESTART, '1, '1, '1);
      send_request(MODE_TRANSLATE, '0, PART_KERNEL, 18'd0);

      // random episodes
      first = skip_map.accepted;
      while (skip_map.accepted - first < 340) begin
         gaps_on = ($urandom_range(0, 9) < 7);
         n = $urandom_range(0, 99);
         if (n < 15) begin
            write_sizes(pick_size(), pick_size(), pick_size());
         end else if (n < 35) begin
            send_request(MODE_RESTART, MARK_W'($urandom), PART_W'($urandom),
                         SECTOR_W'($urandom));
            random_gap();
            scan_blocks(($urandom_range(0, 9) < 8) ? $urandom_range(1, 60)
                                                   : $urandom_range(80, 130),
                        $urandom_range(0, 40));
         end else if (n < 45) begin
            scan_blocks($urandom_range(1, 20), $urandom_range(0, 50));
         end else if (n < 85) begin
            translate_some($urandom_range(5, 30));
         end else if (n < 92) begin
            drain_results();
         end else begin
            // broken sequences: unused mode, stray restart, invalid partition
            repeat ($urandom_range(1, 4)) begin
               send_request(mode_type'($urandom_range(0, 3)), MARK_W'($urandom),
                            ($urandom_range(0, 1) != 0) ? PART_INVALID : PART_W'($urandom),
                            SECTOR_W'($urandom));
               random_gap();
            end
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      $display("Summary: %0d requests (%0d restart, %0d mark, %0d translate, %0d unused), %0d checked",
               skip_map.accepted, skip_map.mode_seen[MODE_RESTART],
               skip_map.mode_seen[MODE_MARK], skip_map.mode_seen[MODE_TRANSLATE],
               skip_map.mode_seen[MODE_UNUSED], skip_map.checked);
      $display("Summary: ok %0d, bad partition %0d, unmapped %0d, outside %0d; peak bad count %0d",
               skip_map.status_seen[STATUS_OK], skip_map.status_seen[STATUS_BAD_PART],
               skip_map.status_seen[STATUS_UNMAPPED], skip_map.status_seen[STATUS_OUTSIDE],
               skip_map.peak_bad);
      if (skip_map.mismatches == 0 && skip_map.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TIMEOUT: %0d results still pending", skip_map.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
